// ----- src/bcrp_pkg.sv -----
// Shared constants, types and helper functions for the bandit replacement policy.
package bcrp_pkg;

  localparam int unsigned NumActionsDefault = 1024;
  localparam int unsigned NumSlotsDefault   = 16;
  localparam int unsigned RewardUnit        = 100;
  localparam int unsigned SqrtSteps         = 16;

  localparam logic signed [31:0] I32Max = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] I32Min = 32'sh8000_0000;

  typedef enum logic [1:0] {
    OP_HIT     = 2'd0,
    OP_RECOMP  = 2'd1,
    OP_PULL    = 2'd2,
    OP_LOAD    = 2'd3
  } op_e;

  localparam logic [1:0] CFG_SELECT_ALL = 2'd0;
  localparam logic [1:0] CFG_ACTIONS    = 2'd1;
  localparam logic [1:0] CFG_SLOTS      = 2'd2;

  // Saturating add of a small signed delta.
  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic signed [8:0] d);
    logic signed [33:0] s;
    s = 34'(signed'(a)) + 34'(d);
    if (s > 34'(I32Max)) return I32Max;
    if (s < 34'(I32Min)) return I32Min;
    return s[31:0];
  endfunction

  // Index of the highest set bit; zero for zero.
  function automatic logic [4:0] flog2(input logic [31:0] v);
    logic [4:0] r;
    r = '0;
    for (int i = 0; i < 32; i++) begin
      if (v[i]) r = 5'(i);
    end
    return r;
  endfunction

endpackage

// ----- src/bcrp_score_unit.sv -----
// Multi-cycle score unit: divide, square root and multiply for one action.
module bcrp_score_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [5:0]  num_i,
  input  logic [31:0] plays_i,
  input  logic [31:0] payoff_i,
  output logic        done_o,
  output logic [31:0] score_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_RAD  = 3'd2;
  localparam logic [2:0] S_SQRT = 3'd3;
  localparam logic [2:0] S_MUL  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0]  state_q, state_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [31:0] plays_q, plays_d;
  logic [31:0] payoff_q, payoff_d;
  logic [5:0]  quot_q, quot_d;
  logic [31:0] rad_q, rad_d;
  logic [31:0] rem_q, rem_d;
  logic [15:0] root_q, root_d;
  logic [63:0] prod_q, prod_d;
  logic [31:0] score_q, score_d;
  logic [6:0]  part;
  logic [33:0] trial;
  logic signed [65:0] full;

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    plays_d  = plays_q;
    payoff_d = payoff_q;
    quot_d   = quot_q;
    rad_d    = rad_q;
    rem_d    = rem_q;
    root_d   = root_q;
    prod_d   = prod_q;
    score_d  = score_q;
    part     = '0;
    trial    = '0;
    full     = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          plays_d  = plays_i;
          payoff_d = payoff_i;
          quot_d   = '0;
          rem_d    = '0;
          cnt_d    = 5'd5;
          state_d  = S_DIV;
        end
      end
      S_DIV: begin
        // One quotient bit per cycle; the partial remainder stays below 64.
        part = {rem_q[5:0], num_i[cnt_q[2:0]]};
        if (32'(part) >= plays_q) begin
          rem_d  = 32'(part) - plays_q;
          quot_d = {quot_q[4:0], 1'b1};
        end else begin
          rem_d  = 32'(part);
          quot_d = {quot_q[4:0], 1'b0};
        end
        if (cnt_q == '0) state_d = S_RAD;
        else cnt_d = cnt_q - 5'd1;
      end
      S_RAD: begin
        // A play count of zero or below gives a zero radicand.
        rad_d   = (plays_q[31] || plays_q == '0) ? '0 : 32'(quot_q) * 32'd10000;
        rem_d   = '0;
        root_d  = '0;
        cnt_d   = 5'(bcrp_pkg::SqrtSteps - 1);
        state_d = S_SQRT;
      end
      S_SQRT: begin
        // One result bit per cycle, restoring method.
        trial = {rem_q, rad_q[31:30]} - {16'd0, root_q, 2'b01};
        rad_d = {rad_q[29:0], 2'b00};
        if (!trial[33]) begin
          rem_d  = trial[31:0];
          root_d = {root_q[14:0], 1'b1};
        end else begin
          rem_d  = {rem_q[29:0], rad_q[31:30]};
          root_d = {root_q[14:0], 1'b0};
        end
        if (cnt_q == '0) state_d = S_MUL;
        else cnt_d = cnt_q - 5'd1;
      end
      S_MUL: begin
        prod_d  = 64'(root_q) * 64'(plays_q);
        state_d = S_OUT;
      end
      S_OUT: begin
        full = -66'(signed'(payoff_q)) - 66'(signed'(prod_q));
        if (full > 66'(bcrp_pkg::I32Max)) score_d = bcrp_pkg::I32Max;
        else if (full < 66'(bcrp_pkg::I32Min)) score_d = bcrp_pkg::I32Min;
        else score_d = full[31:0];
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    plays_q  <= plays_d;
    payoff_q <= payoff_d;
    quot_q   <= quot_d;
    rad_q    <= rad_d;
    rem_q    <= rem_d;
    root_q   <= root_d;
    prod_q   <= prod_d;
    score_q  <= score_d;
  end

  assign done_o  = (state_q == S_OUT);
  assign score_o = score_d;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && state_q == S_IDLE |=> state_q == S_DIV)
    else $error("score unit did not start");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> state_q == S_IDLE)
    else $error("score unit did not return to idle");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_MUL |-> root_q <= 16'd790)
    else $error("square root out of range");

endmodule

// ----- src/bandit_cache_replacement_policy.sv -----
// Top level of the bandit-scored cache replacement policy.
// Hit walks the cached slots, pull the n slots cached (all actions in all mode),
//   load goes straight to the result, and recompute walks every action, each
//   waiting on the score unit (divide, then square root).
// One transaction at a time; the next can be taken in the cycle after the result is taken.
// Reset: a clearing pass over all NumActions entries writes payoff 0, plays 1,
//   score 0 to every entry; input ready stays low until it ends.
module bandit_cache_replacement_policy #(
  parameter int unsigned NumActions = bcrp_pkg::NumActionsDefault,
  parameter int unsigned NumSlots   = bcrp_pkg::NumSlotsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [10:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  op_i,
  input  logic [9:0]  action_id_i,
  input  logic [3:0]  slot_index_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [9:0]  chosen_action_o,
  output logic [1:0]  op_done_o
);

  localparam int unsigned AW = (NumActions > 1) ? $clog2(NumActions) : 1;
  localparam int unsigned SW = (NumSlots > 1) ? $clog2(NumSlots) : 1;

  // Sequencer states.
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RD    = 4'd1;  // issue memory read
  localparam logic [3:0] S_WAIT  = 4'd2;  // read data arrives
  localparam logic [3:0] S_MOD   = 4'd3;  // hit: modify and write back; else start score or compare
  localparam logic [3:0] S_SCORE = 4'd4;  // wait on score unit
  localparam logic [3:0] S_PRD   = 4'd5;  // pull: read chosen
  localparam logic [3:0] S_PWAIT = 4'd6;
  localparam logic [3:0] S_PWR   = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;
  localparam logic [3:0] S_CLR   = 4'd9;  // clear every entry after reset

  // Configuration.
  logic        sel_all_q;
  logic [10:0] n_act_q;
  logic [4:0]  n_slot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_all_q <= 1'b0;
      n_act_q   <= 11'd1024;
      n_slot_q  <= 5'd16;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        bcrp_pkg::CFG_SELECT_ALL: sel_all_q <= cfg_data_i[0];
        bcrp_pkg::CFG_ACTIONS:    n_act_q   <= cfg_data_i;
        bcrp_pkg::CFG_SLOTS:      n_slot_q  <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  logic [16:0] eff_act, eff_slot;
  assign eff_act  = (17'(n_act_q) > 17'(NumActions)) ? 17'(NumActions) : 17'(n_act_q);
  assign eff_slot = (17'(n_slot_q) > 17'(NumSlots)) ? 17'(NumSlots) : 17'(n_slot_q);

  // Per-action memory: payoff, plays, score in one 96-bit word.
  logic [95:0]  mem [NumActions];
  logic [AW-1:0] rd_addr, wr_addr;
  logic          wr_en;
  logic [95:0]   wr_data, rd_raw_q, rd_word;

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_raw_q <= mem[rd_addr];
  end

  // Every entry is written by the clearing pass before any read data is used.
  assign rd_word = rd_raw_q;

  // Slot table in flip-flops, read at the walk index and at slot 0.
  logic [AW-1:0] slot_q [NumSlots];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumSlots; i++) slot_q[i] <= AW'(i % NumActions);
    end else if (in_valid_i && in_ready_o && op_i == bcrp_pkg::OP_LOAD
                 && 32'(slot_index_i) < NumSlots && 32'(action_id_i) < NumActions) begin
      slot_q[SW'(slot_index_i)] <= AW'(action_id_i);
    end
  end

  // Sequencer registers.
  logic [3:0]    state_q;
  logic [1:0]    op_q;
  logic [9:0]    act_q;
  logic [16:0]   idx_q;
  logic [AW-1:0] cur_q, best_q;
  logic [31:0]   best_sc_q;
  logic [31:0]   step_q;
  logic [5:0]    lg2_q;
  logic [9:0]    chosen_q;
  logic          sc_start, sc_done;
  logic [31:0]   sc_score;

  logic [16:0] walk_n;
  assign walk_n = (op_q == bcrp_pkg::OP_PULL && sel_all_q) ? eff_act :
                  (op_q == bcrp_pkg::OP_RECOMP) ? eff_act : eff_slot;

  logic [AW-1:0] walk_addr;
  assign walk_addr = ((op_q == bcrp_pkg::OP_RECOMP) ||
                      (op_q == bcrp_pkg::OP_PULL && sel_all_q)) ?
                     AW'(idx_q) : slot_q[SW'(idx_q)];

  // Hold the chosen address through the pull update's read states, S_PRD and S_PWAIT.
  always_comb begin
    rd_addr = walk_addr;
    if (state_q == S_PRD || state_q == S_PWAIT) rd_addr = best_q;
  end

  logic signed [8:0] delta;
  assign delta = (10'(cur_q) == act_q) ? 9'sd100 : -9'sd100;

  // Keep the entry's payoff and plays for the write-back after the score unit; the read port moves on.
  logic [95:0] sc_word_q;
  always_ff @(posedge clk_i) begin
    if (state_q == S_MOD) sc_word_q <= rd_word;
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cur_q;
    wr_data = rd_word;
    sc_start = 1'b0;
    if (state_q == S_CLR) begin
      wr_en   = 1'b1;
      wr_addr = AW'(idx_q);
      wr_data = {32'd0, 32'd1, 32'd0};
    end else if (state_q == S_MOD && op_q == bcrp_pkg::OP_HIT) begin
      wr_en   = 1'b1;
      wr_data = {bcrp_pkg::sat_add(rd_word[95:64], delta), rd_word[63:0]};
    end else if (state_q == S_MOD && op_q == bcrp_pkg::OP_RECOMP) begin
      sc_start = 1'b1;
    end else if (state_q == S_SCORE && sc_done) begin
      wr_en   = 1'b1;
      wr_data = {sc_word_q[95:32], sc_score};
    end else if (state_q == S_PWR) begin
      wr_en   = 1'b1;
      wr_addr = best_q;
      wr_data = {bcrp_pkg::sat_add(rd_word[95:64], 9'sd100),
                 bcrp_pkg::sat_add(rd_word[63:32], 9'sd100), rd_word[31:0]};
    end
  end

  bcrp_score_unit u_score (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (sc_start),
    .num_i    ({lg2_q[4:0], 1'b0}),
    .plays_i  (rd_word[63:32]),
    .payoff_i (rd_word[95:64]),
    .done_o   (sc_done),
    .score_o  (sc_score)
  );

  logic [31:0] step_inc;
  assign step_inc = bcrp_pkg::sat_add(step_q, 9'sd100);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLR;
      op_q      <= bcrp_pkg::OP_HIT;
      act_q     <= '0;
      idx_q     <= '0;
      cur_q     <= '0;
      best_q    <= '0;
      best_sc_q <= '0;
      step_q    <= 32'(NumActions);
      lg2_q     <= '0;
      chosen_q  <= '0;
    end else begin
      case (state_q)
        S_CLR: begin
          idx_q <= idx_q + 17'd1;
          if (idx_q == 17'(NumActions - 1)) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid_i) begin
            op_q     <= op_i;
            act_q    <= action_id_i;
            idx_q    <= '0;
            chosen_q <= '0;
            lg2_q    <= {1'b0, bcrp_pkg::flog2(bcrp_pkg::sat_add(step_q, 9'sd1))};
            state_q  <= (op_i == bcrp_pkg::OP_LOAD) ? S_OUT : S_RD;
          end
        end
        S_RD: begin
          if (idx_q >= walk_n) begin
            if (op_q == bcrp_pkg::OP_PULL) begin
              if (idx_q == '0) best_q <= sel_all_q ? '0 : slot_q[0];
              state_q <= S_PRD;
            end else begin
              state_q <= S_OUT;
            end
          end else begin
            cur_q   <= walk_addr;
            state_q <= S_WAIT;
          end
        end
        S_WAIT: state_q <= S_MOD;
        S_MOD: begin
          idx_q <= idx_q + 17'd1;
          if (op_q == bcrp_pkg::OP_HIT) begin
            step_q  <= step_inc;
            state_q <= S_RD;
          end else if (op_q == bcrp_pkg::OP_RECOMP) begin
            state_q <= S_SCORE;
          end else begin
            // Pull search: the first entry seeds, later ones win only if strictly greater.
            if (idx_q == '0 || signed'(rd_word[31:0]) > signed'(best_sc_q)) begin
              if (!(idx_q == '0 && !sel_all_q && cur_q != slot_q[0] &&
                    signed'(rd_word[31:0]) <= 0)) begin
                best_q    <= cur_q;
                best_sc_q <= rd_word[31:0];
              end
            end
            state_q <= S_RD;
          end
        end
        S_SCORE: if (sc_done) state_q <= S_RD;
        S_PRD:   state_q <= S_PWAIT;
        S_PWAIT: state_q <= S_PWR;
        S_PWR: begin
          step_q   <= step_inc;
          chosen_q <= 10'(best_q);
          state_q  <= S_OUT;
        end
        S_OUT: if (out_ready_i) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o      = (state_q == S_IDLE);
  assign out_valid_o     = (state_q == S_OUT);
  assign chosen_action_o = chosen_q;
  assign op_done_o       = op_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("accepted a transaction while a result is pending");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(chosen_action_o))
    else $error("result dropped before acceptance");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && op_done_o != bcrp_pkg::OP_PULL |-> chosen_action_o == '0)
    else $error("nonzero action on non-pull result");

endmodule
